// ===== hw/rtl/arad_pkg.sv =====
// shared constants, codes and types of the adaptive rate activity detector
package arad_pkg;

    // default sizing
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int MAX_CHUNK_DEF   = 1024;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BASELINE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_THR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SILENCE_TMO = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LEN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LEN  = 3'd5;

    // register reset values
    localparam logic [11:0] BASELINE_RST    = 12'd2048;
    localparam logic [23:0] ENERGY_THR_RST  = 24'd100;
    localparam logic [11:0] PEAK_THR_RST    = 12'd512;
    localparam logic [31:0] SILENCE_TMO_RST = 32'd5000;
    localparam logic [10:0] IDLE_LEN_RST    = 11'd128;
    localparam logic [10:0] ACTIVE_LEN_RST  = 11'd512;

    // item opcodes
    localparam logic [1:0] OP_SAMPLE     = 2'd0;
    localparam logic [1:0] OP_TICK       = 2'd1;
    localparam logic [1:0] OP_FORCE_IDLE = 2'd2;

    // reported mode codes
    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_ACTIVE = 2'd1;
    localparam logic [1:0] MODE_PROC   = 2'd2;

    // saturation limits
    localparam logic [23:0] ENERGY_MAX = 24'hFF_FFFF;
    localparam logic [11:0] PEAK_MAX   = 12'hFFF;
    localparam logic [31:0] TIMER_MAX  = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        chunk_done;
        logic [23:0] mean_energy;
        logic [11:0] peak_level;
        logic [1:0]  mode;
        logic        high_res;
        logic [31:0] switch_count;
        logic [31:0] samples_total;
    } report_t;

endpackage

// ===== hw/rtl/arad_sample_if.sv =====
// item channel carrying opcodes and raw adc samples
interface arad_sample_if #(
    parameter int SAMPLE_BITS = arad_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             op;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output op, output sample, input ready);
    modport sink   (input valid, input op, input sample, output ready);
endinterface

// ===== hw/rtl/arad_report_if.sv =====
// item channel carrying the status report of each processed item
interface arad_report_if;
    logic        valid;
    logic        ready;
    logic        chunk_done;
    logic [23:0] mean_energy;
    logic [11:0] peak_level;
    logic [1:0]  mode;
    logic        high_res;
    logic [31:0] switch_count;
    logic [31:0] samples_total;

    modport source (
        output valid, output chunk_done, output mean_energy, output peak_level,
        output mode, output high_res, output switch_count, output samples_total,
        input ready
    );
    modport sink (
        input valid, input chunk_done, input mean_energy, input peak_level,
        input mode, input high_res, input switch_count, input samples_total,
        output ready
    );
endinterface

// ===== hw/rtl/adaptive_rate_activity_detector.sv =====
// adaptive rate activity detector: chunk energy, peak and mode machine
//
//  channel   dir  handshake      payload
//  samples   in   valid/ready    op, sample
//  results   out  valid/ready    chunk_done, mean_energy, peak_level, mode,
//                                high_res, switch_count, samples_total
//  cfg       in   cfg_we         cfg_index, cfg_data (write only)
//
//  tick, force idle and spare opcodes go through REPORT, a sample that leaves
//  its chunk open through ACCUM and REPORT, and one that closes it through
//  ACCUM, DIV, CLOSE and REPORT; DIV is a one bit per cycle restoring divider
//  rst_n (async) clears all but scratch and rpt_reg; there is no clearing pass
//  one item at a time: samples.ready is high only when the sequencer is idle
//  and the report register is empty or being emptied in the same cycle
//  a stalled report holds its register; no further item is taken until it goes
module adaptive_rate_activity_detector #(
    parameter int SAMPLE_BITS = arad_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_CHUNK   = arad_pkg::MAX_CHUNK_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    arad_sample_if.sink                      samples,
    arad_report_if.source                    results,
    input  logic                             cfg_we,
    input  logic [arad_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [arad_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import arad_pkg::*;

    // count holds up to MAX_CHUNK; the sum holds MAX_CHUNK squared deviations
    localparam int CNTW = $clog2(MAX_CHUNK + 1);
    localparam int CMPW = (CNTW > 11) ? CNTW : 11;
    localparam int SQW  = 2 * SAMPLE_BITS;
    localparam int SUMW = SQW + CNTW;
    localparam int DCW  = $clog2(SUMW + 1);

    // sequencer
    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ACCUM  = 5'b00010,
        S_DIV    = 5'b00100,
        S_CLOSE  = 5'b01000,
        S_REPORT = 5'b10000
    } seq_t;

    seq_t state_reg, state_next;

    // configuration
    logic [11:0] baseline_reg;
    logic [23:0] energy_thr_reg;
    logic [11:0] peak_thr_reg;
    logic [31:0] silence_tmo_reg;
    logic [10:0] idle_len_reg;
    logic [10:0] active_len_reg;

    // detector state
    logic [SUMW-1:0]        energy_sum_reg;
    logic [SAMPLE_BITS-1:0] chunk_peak_reg;
    logic [CNTW-1:0]        chunk_count_reg;
    logic [23:0]            last_energy_reg;
    logic [11:0]            last_peak_reg;
    logic [1:0]             mode_reg;
    logic                   rate_high_reg;
    logic [31:0]            silence_ms_reg;
    logic [31:0]            switches_reg;
    logic [31:0]            sample_total_reg;
    logic                   done_reg;

    // datapath scratch
    logic [SAMPLE_BITS-1:0] dev_reg;
    logic [SUMW-1:0]        div_num_reg;
    logic [CNTW-1:0]        div_den_reg;
    logic [CNTW-1:0]        div_rem_reg;
    logic [DCW-1:0]         div_cnt_reg;

    // report register
    report_t rpt_reg;
    logic    rpt_valid_reg;

    logic                   accept;
    logic                   rpt_take;
    logic [SAMPLE_BITS-1:0] base_w;
    logic [SAMPLE_BITS-1:0] dev_w;
    logic [SQW-1:0]         sq_w;
    logic [SUMW-1:0]        sum_new;
    logic [SAMPLE_BITS-1:0] peak_new;
    logic [CNTW-1:0]        count_new;
    logic [10:0]            len_raw;
    logic [CMPW-1:0]        len_eff;
    logic                   closes;
    logic [CNTW:0]          div_trial;
    logic                   div_ge;
    logic [23:0]            mean_sat;
    logic [11:0]            peak_sat;

    assign rpt_take = rpt_valid_reg && results.ready;
    assign samples.ready = (state_reg == S_IDLE) && (!rpt_valid_reg || results.ready);
    assign accept = samples.valid && samples.ready;

    // absolute deviation from the baseline, both at sample width
    assign base_w = SAMPLE_BITS'(baseline_reg);
    assign dev_w  = (samples.sample >= base_w) ? (samples.sample - base_w)
                                               : (base_w - samples.sample);

    // one squaring and accumulate step per sample
    assign sq_w      = dev_reg * dev_reg;
    assign sum_new   = energy_sum_reg + SUMW'(sq_w);
    assign peak_new  = (dev_reg > chunk_peak_reg) ? dev_reg : chunk_peak_reg;
    assign count_new = chunk_count_reg + CNTW'(1);

    // chunk length of the current rate, zero read as one, capped at MAX_CHUNK
    assign len_raw = rate_high_reg ? active_len_reg : idle_len_reg;
    always_comb
    begin
        priority if (len_raw == 11'd0)
        begin
            len_eff = CMPW'(1);
        end
        else if (CMPW'(len_raw) > CMPW'(MAX_CHUNK))
        begin
            len_eff = CMPW'(MAX_CHUNK);
        end
        else
        begin
            len_eff = CMPW'(len_raw);
        end
    end
    // a chunk shortened by force idle closes on the next sample
    assign closes = CMPW'(count_new) >= len_eff;

    // restoring divider step: shift in the next dividend bit, try to subtract
    assign div_trial = {div_rem_reg, div_num_reg[SUMW-1]};
    assign div_ge    = div_trial >= {1'b0, div_den_reg};

    // quotient sits in div_num_reg once the divider has run
    assign mean_sat = (64'(div_num_reg) > 64'(ENERGY_MAX)) ? ENERGY_MAX
                                                           : 24'(div_num_reg);
    assign peak_sat = (32'(peak_new) > 32'(PEAK_MAX)) ? PEAK_MAX : 12'(peak_new);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (samples.op == OP_SAMPLE) ? S_ACCUM : S_REPORT;
                end
            end
            S_ACCUM:  state_next = closes ? S_DIV : S_REPORT;
            S_DIV:    state_next = (div_cnt_reg == DCW'(1)) ? S_CLOSE : S_DIV;
            S_CLOSE:  state_next = S_REPORT;
            S_REPORT: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers: write only while idle; the block does not check
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            baseline_reg    <= BASELINE_RST;
            energy_thr_reg  <= ENERGY_THR_RST;
            peak_thr_reg    <= PEAK_THR_RST;
            silence_tmo_reg <= SILENCE_TMO_RST;
            idle_len_reg    <= IDLE_LEN_RST;
            active_len_reg  <= ACTIVE_LEN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BASELINE:    baseline_reg    <= cfg_data[11:0];
                REG_ENERGY_THR:  energy_thr_reg  <= cfg_data[23:0];
                REG_PEAK_THR:    peak_thr_reg    <= cfg_data[11:0];
                REG_SILENCE_TMO: silence_tmo_reg <= cfg_data;
                REG_IDLE_LEN:    idle_len_reg    <= cfg_data[10:0];
                REG_ACTIVE_LEN:  active_len_reg  <= cfg_data[10:0];
                default:         ;
            endcase
        end
    end

    // detector state and mode machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            energy_sum_reg   <= '0;
            chunk_peak_reg   <= '0;
            chunk_count_reg  <= '0;
            last_energy_reg  <= '0;
            last_peak_reg    <= '0;
            mode_reg         <= MODE_IDLE;
            rate_high_reg    <= 1'b0;
            silence_ms_reg   <= '0;
            switches_reg     <= '0;
            sample_total_reg <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        done_reg <= 1'b0;
                        priority if (samples.op == OP_TICK)
                        begin
                            // saturating silence timer
                            if (silence_ms_reg != TIMER_MAX)
                            begin
                                silence_ms_reg <= silence_ms_reg + 32'd1;
                            end
                        end
                        else if (samples.op == OP_FORCE_IDLE)
                        begin
                            // open chunk, counters and timer are kept
                            mode_reg      <= MODE_IDLE;
                            rate_high_reg <= 1'b0;
                        end
                        else
                        begin
                        end
                    end
                end
                S_ACCUM:
                begin
                    if (closes)
                    begin
                        last_peak_reg    <= peak_sat;
                        sample_total_reg <= sample_total_reg + 32'(count_new);
                        energy_sum_reg   <= '0;
                        chunk_peak_reg   <= '0;
                        chunk_count_reg  <= '0;
                        done_reg         <= 1'b1;
                    end
                    else
                    begin
                        energy_sum_reg  <= sum_new;
                        chunk_peak_reg  <= peak_new;
                        chunk_count_reg <= count_new;
                    end
                end
                S_CLOSE:
                begin
                    last_energy_reg <= mean_sat;
                    unique case (mode_reg)
                        MODE_IDLE:
                        begin
                            if (mean_sat > energy_thr_reg || last_peak_reg > peak_thr_reg)
                            begin
                                mode_reg       <= MODE_ACTIVE;
                                rate_high_reg  <= 1'b1;
                                switches_reg   <= switches_reg + 32'd1;
                                silence_ms_reg <= '0;
                            end
                        end
                        MODE_ACTIVE, MODE_PROC:
                        begin
                            if (silence_ms_reg > silence_tmo_reg ||
                                mean_sat < (energy_thr_reg >> 2))
                            begin
                                mode_reg      <= MODE_IDLE;
                                rate_high_reg <= 1'b0;
                            end
                            else
                            begin
                                mode_reg <= MODE_PROC;
                            end
                        end
                        default: mode_reg <= MODE_IDLE;
                    endcase
                end
                S_DIV, S_REPORT: ;
                default: ;
            endcase
        end
    end

    // datapath scratch: deviation, divider operands and iteration count
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dev_reg <= dev_w;
        end
        if (state_reg == S_ACCUM)
        begin
            div_num_reg <= sum_new;
            div_den_reg <= count_new;
            div_rem_reg <= '0;
            div_cnt_reg <= DCW'(SUMW);
        end
        else if (state_reg == S_DIV)
        begin
            // dividend shifts out at the top, quotient bits enter at the bottom
            div_num_reg <= {div_num_reg[SUMW-2:0], div_ge};
            div_rem_reg <= div_ge ? CNTW'(div_trial - {1'b0, div_den_reg})
                                  : CNTW'(div_trial);
            div_cnt_reg <= div_cnt_reg - DCW'(1);
        end
    end

    // report register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpt_valid_reg <= 1'b0;
        end
        else if (state_reg == S_REPORT)
        begin
            rpt_valid_reg <= 1'b1;
        end
        else if (rpt_take)
        begin
            rpt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_REPORT)
        begin
            rpt_reg.chunk_done    <= done_reg;
            rpt_reg.mean_energy   <= last_energy_reg;
            rpt_reg.peak_level    <= last_peak_reg;
            rpt_reg.mode          <= mode_reg;
            rpt_reg.high_res      <= rate_high_reg;
            rpt_reg.switch_count  <= switches_reg;
            rpt_reg.samples_total <= sample_total_reg;
        end
    end

    assign results.valid         = rpt_valid_reg;
    assign results.chunk_done    = rpt_reg.chunk_done;
    assign results.mean_energy   = rpt_reg.mean_energy;
    assign results.peak_level    = rpt_reg.peak_level;
    assign results.mode          = rpt_reg.mode;
    assign results.high_res      = rpt_reg.high_res;
    assign results.switch_count  = rpt_reg.switch_count;
    assign results.samples_total = rpt_reg.samples_total;

endmodule

// ===== sim/tb_adaptive_rate_activity_detector.sv =====
// self-checking testbench of the adaptive rate activity detector with its own status predictor
module tb_adaptive_rate_activity_detector;
    timeunit 1ns;
    timeprecision 1ps;

    import arad_pkg::*;

    // op code that the block does not define; it must change nothing
    localparam logic [1:0] OP_SPARE = 2'd3;

    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int SETTLE_CYCLES = 60;      // beyond the slowest chunk close
    localparam int NUM_PHASES    = 8;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] sample;
    } detector_item_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    arad_sample_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) sample_ch ();
    arad_report_if report_ch ();

    adaptive_rate_activity_detector #(
        .SAMPLE_BITS (SAMPLE_BITS_DEF),
        .MAX_CHUNK   (MAX_CHUNK_DEF)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (sample_ch),
        .results   (report_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // items waiting for the driver, status reports waiting for the block
    detector_item_t pending_items[$];
    report_t        expected_reports[$];

    // register copies as the predictor sees them
    logic [11:0] set_baseline;
    logic [23:0] set_energy_thr;
    logic [11:0] set_peak_thr;
    logic [31:0] set_timeout;
    logic [10:0] set_idle_len;
    logic [10:0] set_active_len;

    // predicted detector state
    logic [63:0] sq_dev_sum;
    logic [11:0] open_peak;
    logic [10:0] open_count;
    logic [23:0] held_energy;
    logic [11:0] held_peak;
    logic [1:0]  cur_mode;
    logic        fast_rate;
    logic [31:0] quiet_ms;
    logic [31:0] switch_tally;
    logic [31:0] closed_samples;

    // handshake pacing, set by the stimulus process
    int tx_idle_pct;
    int rx_idle_pct;
    bit rx_hold;

    int mismatches;
    int items_accepted;
    int reports_checked;
    int chunks_closed;
    int settings_loaded;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // status predictor: one report per accepted item
    // ------------------------------------------------------------------
    function automatic report_t step_detector(input logic [1:0] op, input logic [11:0] smp);
        report_t     rep;
        logic [11:0] dev;
        logic [10:0] limit;
        logic [63:0] mean;
        rep.chunk_done = 1'b0;
        case (op)
            OP_SAMPLE:
            begin
                dev = (smp >= set_baseline) ? smp - set_baseline : set_baseline - smp;
                sq_dev_sum = sq_dev_sum + 64'(dev) * 64'(dev);
                if (dev > open_peak)
                    open_peak = dev;
                if (open_count != 11'h7FF)
                    open_count = open_count + 11'd1;
                // chunk length of the current rate, zero counts as one, capped at the maximum
                limit = fast_rate ? set_active_len : set_idle_len;
                if (limit == 11'd0)
                    limit = 11'd1;
                if (limit > MAX_CHUNK_DEF)
                    limit = 11'(MAX_CHUNK_DEF);
                // a count already past the length (after a force idle) closes here too
                if (open_count >= limit)
                begin
                    mean = sq_dev_sum / 64'(open_count);
                    held_energy = (mean > 64'(ENERGY_MAX)) ? ENERGY_MAX : mean[23:0];
                    held_peak = open_peak;
                    closed_samples = closed_samples + 32'(open_count);
                    sq_dev_sum = '0;
                    open_peak = '0;
                    open_count = '0;
                    rep.chunk_done = 1'b1;
                    chunks_closed++;
                    // mode machine runs on the freshly closed chunk
                    case (cur_mode)
                        MODE_IDLE:
                        begin
                            if (held_energy > set_energy_thr || held_peak > set_peak_thr)
                            begin
                                cur_mode = MODE_ACTIVE;
                                fast_rate = 1'b1;
                                switch_tally = switch_tally + 32'd1;
                                quiet_ms = '0;
                            end
                        end
                        MODE_ACTIVE, MODE_PROC:
                        begin
                            if (quiet_ms > set_timeout || held_energy < (set_energy_thr >> 2))
                            begin
                                cur_mode = MODE_IDLE;
                                fast_rate = 1'b0;
                            end
                            else
                                cur_mode = MODE_PROC;
                        end
                        default: cur_mode = MODE_IDLE;
                    endcase
                end
            end
            OP_TICK:
            begin
                // silence timer saturates
                if (quiet_ms != TIMER_MAX)
                    quiet_ms = quiet_ms + 32'd1;
            end
            OP_FORCE_IDLE:
            begin
                // open chunk, counters and timer stay as they are
                cur_mode = MODE_IDLE;
                fast_rate = 1'b0;
            end
            default: ;
        endcase
        rep.mean_energy   = held_energy;
        rep.peak_level    = held_peak;
        rep.mode          = cur_mode;
        rep.high_res      = fast_rate;
        rep.switch_count  = switch_tally;
        rep.samples_total = closed_samples;
        return rep;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch in %s of report %0d: expected %0h, got %0h",
                         name, reports_checked, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: offers pending items, predicts each one as it is taken
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        detector_item_t nxt;
        if (!rst_n)
        begin
            sample_ch.valid  <= 1'b0;
            sample_ch.op     <= OP_SAMPLE;
            sample_ch.sample <= '0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                expected_reports.push_back(step_detector(sample_ch.op, sample_ch.sample));
                items_accepted++;
            end
            // only move on once the offered item has gone
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    nxt = pending_items.pop_front();
                    sample_ch.valid  <= 1'b1;
                    sample_ch.op     <= nxt.op;
                    sample_ch.sample <= nxt.sample;
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each taken report against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        report_t want;
        if (!rst_n)
            report_ch.ready <= 1'b0;
        else
        begin
            if (report_ch.valid && report_ch.ready)
            begin
                reports_checked++;
                if (expected_reports.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("report %0d arrived with no item to account for it",
                                 reports_checked);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("chunk_done", 32'(want.chunk_done), 32'(report_ch.chunk_done));
                    check_field("mean_energy", 32'(want.mean_energy),
                                32'(report_ch.mean_energy));
                    check_field("peak_level", 32'(want.peak_level), 32'(report_ch.peak_level));
                    check_field("mode", 32'(want.mode), 32'(report_ch.mode));
                    check_field("high_res", 32'(want.high_res), 32'(report_ch.high_res));
                    check_field("switch_count", want.switch_count, report_ch.switch_count);
                    check_field("samples_total", want.samples_total, report_ch.samples_total);
                end
            end
            report_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(input logic [1:0] op, input logic [11:0] smp);
        detector_item_t it;
        it.op = op;
        it.sample = smp;
        pending_items.push_back(it);
    endtask

    // sample scattered around the baseline, clipped to the adc range
    function automatic logic [11:0] near_baseline(input int spread);
        int v;
        v = int'(set_baseline) + int'($urandom_range(2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > 4095)
            v = 4095;
        return 12'(v);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_BASELINE:    set_baseline   = value[11:0];
            REG_ENERGY_THR:  set_energy_thr = value[23:0];
            REG_PEAK_THR:    set_peak_thr   = value[11:0];
            REG_SILENCE_TMO: set_timeout    = value;
            REG_IDLE_LEN:    set_idle_len   = value[10:0];
            REG_ACTIVE_LEN:  set_active_len = value[10:0];
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [31:0] baseline, input logic [31:0] energy_thr,
                                 input logic [31:0] peak_thr, input logic [31:0] timeout,
                                 input logic [31:0] idle_len, input logic [31:0] active_len);
        write_reg(REG_BASELINE, baseline);
        write_reg(REG_ENERGY_THR, energy_thr);
        write_reg(REG_PEAK_THR, peak_thr);
        write_reg(REG_SILENCE_TMO, timeout);
        write_reg(REG_IDLE_LEN, idle_len);
        write_reg(REG_ACTIVE_LEN, active_len);
        settings_loaded++;
    endtask

    // random settings with short chunks so that the mode machine turns often
    task automatic pick_settings();
        logic [31:0] thr;
        logic [31:0] tmo;
        case ($urandom_range(3))
            0: thr = $urandom_range(0, 50);
            1: thr = $urandom_range(50, 5000);
            2: thr = $urandom_range(5000, 200000);
            default: thr = $urandom_range(0, 24'hFF_FFFF);
        endcase
        case ($urandom_range(3))
            0: tmo = $urandom_range(0, 20);
            1: tmo = $urandom_range(20, 300);
            2: tmo = TIMER_MAX;
            default: tmo = $urandom;
        endcase
        load_settings($urandom_range(4095), thr,
                      $urandom_range(1) ? $urandom_range(4095) : $urandom_range(600),
                      tmo, $urandom_range(0, 6), $urandom_range(0, 10));
    endtask

    // mostly bursts of samples of one loudness and runs of ticks, some force idles
    // and stray op codes; ignored items are not counted
    task automatic queue_traffic(input int n);
        int added;
        int burst;
        int kind;
        int spread;
        added = 0;
        while (added < n)
        begin
            kind = $urandom_range(99);
            burst = $urandom_range(1, 12);
            if (kind < 60)
            begin
                case ($urandom_range(2))
                    0: spread = $urandom_range(0, 8);
                    1: spread = $urandom_range(8, 300);
                    default: spread = -1;
                endcase
                repeat (burst)
                    add_item(OP_SAMPLE, (spread < 0) ? 12'($urandom) : near_baseline(spread));
                added += burst;
            end
            else if (kind < 80)
            begin
                repeat (burst)
                    add_item(OP_TICK, 12'($urandom));
                added += burst;
            end
            else if (kind < 88)
            begin
                add_item(OP_FORCE_IDLE, 12'($urandom));
                added++;
            end
            else if (kind < 92)
                add_item(OP_SPARE, 12'($urandom));
            else
            begin
                add_item(OP_SAMPLE, 12'($urandom));
                added++;
            end
        end
    endtask

    // block is idle once every item has gone in and every report has come out
    task automatic wait_drained();
        @(negedge clk);
        while (pending_items.size() != 0 || sample_ch.valid || expected_reports.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.op = OP_SAMPLE;
        sample_ch.sample = '0;
        report_ch.ready = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold = 1'b0;
        mismatches = 0;
        items_accepted = 0;
        reports_checked = 0;
        chunks_closed = 0;
        settings_loaded = 0;

        // predictor starts from the reset state
        set_baseline = BASELINE_RST;
        set_energy_thr = ENERGY_THR_RST;
        set_peak_thr = PEAK_THR_RST;
        set_timeout = SILENCE_TMO_RST;
        set_idle_len = IDLE_LEN_RST;
        set_active_len = ACTIVE_LEN_RST;
        sq_dev_sum = '0;
        open_peak = '0;
        open_count = '0;
        held_energy = '0;
        held_peak = '0;
        cur_mode = MODE_IDLE;
        fast_rate = 1'b0;
        quiet_ms = '0;
        switch_tally = '0;
        closed_samples = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            wait_drained();
            // fast sender and busy receiver first, then the reverse, then full speed
            if (phase < 3)
            begin
                tx_idle_pct = 9;
                rx_idle_pct = 74;
            end
            else if (phase < 6)
            begin
                tx_idle_pct = 74;
                rx_idle_pct = 9;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            case (phase)
                0:
                begin
                    // directed walk through every op and every mode change
                    load_settings(32'd2048, 32'd100, 32'd512, 32'd3, 32'd0, 32'd3);
                    add_item(OP_SPARE, 12'hFFF);
                    add_item(OP_TICK, 12'h000);
                    add_item(OP_SAMPLE, 12'd2048);      // zero deviation, zero length chunk
                    add_item(OP_SAMPLE, 12'd0);         // loud: idle to active
                    add_item(OP_SAMPLE, 12'hFFF);
                    add_item(OP_SAMPLE, 12'd2100);
                    add_item(OP_SAMPLE, 12'd2000);      // closes active chunk: processing
                    repeat (5) add_item(OP_TICK, 12'hFFF);
                    add_item(OP_SAMPLE, 12'hFFF);
                    add_item(OP_SAMPLE, 12'd0);
                    add_item(OP_SAMPLE, 12'hFFF);       // silence timeout: back to idle
                    add_item(OP_SAMPLE, 12'd0);         // active again
                    add_item(OP_SAMPLE, 12'hFFF);
                    add_item(OP_FORCE_IDLE, 12'd0);
                    add_item(OP_SAMPLE, 12'hFFF);       // count past the idle length
                    repeat (3) add_item(OP_SAMPLE, 12'd2048); // quiet chunk drops to idle
                    add_item(OP_FORCE_IDLE, 12'hFFF);
                    add_item(OP_SPARE, 12'h000);
                end
                1:
                begin
                    load_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1);
                    queue_traffic(100);
                end
                2:
                begin
                    // thresholds out of reach, zero lengths
                    load_settings(32'd4095, 32'(ENERGY_MAX), 32'(PEAK_MAX), TIMER_MAX,
                                  32'd0, 32'd0);
                    queue_traffic(60);
                end
                4:
                begin
                    // longest chunk: idle length above the cap fills a full chunk
                    load_settings(32'd2048, 32'd5000, 32'd4095, TIMER_MAX, 32'd2047, 32'd1024);
                    repeat (MAX_CHUNK_DEF) add_item(OP_SAMPLE, 12'($urandom));
                    repeat (30) add_item(OP_SAMPLE, near_baseline(200));
                    add_item(OP_FORCE_IDLE, 12'($urandom));
                    add_item(OP_TICK, 12'($urandom));
                end
                default:
                begin
                    pick_settings();
                    queue_traffic(125);
                    if (phase == 6)
                    begin
                        // receiver holds off while the sender keeps offering
                        @(negedge clk);
                        rx_hold = 1'b1;
                        repeat (HOLD_CYCLES) @(negedge clk);
                        rx_hold = 1'b0;
                    end
                end
            endcase
        end
        wait_drained();

        $display("covered %0d items under %0d register settings, %0d reports checked",
                 items_accepted, settings_loaded, reports_checked);
        $display("%0d chunks closed, %0d idle to active switches, %0d mismatches",
                 chunks_closed, switch_tally, mismatches);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog well beyond the slowest correct run
    initial
    begin
        #8_000_000;
        $display("timed out with %0d reports outstanding", expected_reports.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
